@@ rtl/priority_round_robin_picker_macros.svh @@
// Assertion macros used by the port-level checker of the task picker.
`ifndef PRIORITY_ROUND_ROBIN_PICKER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_PICKER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low
`define PRRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prrp check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low
`define PRRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prrp check failed");

`endif

@@ rtl/prrp_pkg.sv @@
// Types, sizes and codes shared by the task picker, its checkers and the testbench.
package prrp_pkg;

    // Table sizes
    localparam int TASK_COUNT    = 1024;
    localparam int CPU_COUNT     = 8;
    localparam int PRIORITY_BITS = 8;

    localparam int IDX_W   = $clog2(TASK_COUNT);
    localparam int ENTRY_W = 3 + 1 + PRIORITY_BITS;

    // Stream field widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;
    localparam int FIELD_IDX_W = 10;

    // Item kinds carried in tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_YIELD = 1'b1;

    // Task status codes
    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;

    typedef enum logic [2:0] {
        DEC_CURRENT = 3'd0,
        DEC_PICKED  = 3'd1,
        DEC_IDLE    = 3'd2,
        DEC_NONE    = 3'd3,
        DEC_NO_IDLE = 3'd4
    } decision_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [2:0]               status;
        logic                     is_idle;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

endpackage

@@ rtl/prrp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module prrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/priority_round_robin_picker.sv @@
// Yield: the task table RAM is read once per cycle over every entry (states SCAN, DRAIN),
// then the result is loaded into the output register in EMIT once the output is free;
// the next item enters only after that load, so one yield is handled at a time.
// Write item: no result; the input stays ready, so write items can follow back to back.
// Reset (rst_n low, asynchronous) starts a clearing pass that writes every entry
// free; tready stays low until it is done.
module priority_round_robin_picker
    import prrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tdata: entry_index[9:0], entry_status[12:10], entry_is_idle[13],
    //        entry_priority[21:14], has_current[22], current_index[32:23],
    //        cpu_number[35:33], zero fill[39:36]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[0]
    input  logic                  s_axis_tuser,
    // tdata: decision[2:0], chosen_index[12:3], zero fill[15:13]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

    // Unpacked input fields
    logic [9:0]               in_entry_index;
    logic [2:0]               in_entry_status;
    logic                     in_entry_is_idle;
    logic [7:0]               in_entry_priority;
    logic                     in_has_current;
    logic [9:0]               in_current_index;
    logic [2:0]               in_cpu_number;

    assign in_entry_index    = s_axis_tdata[9:0];
    assign in_entry_status   = s_axis_tdata[12:10];
    assign in_entry_is_idle  = s_axis_tdata[13];
    assign in_entry_priority = s_axis_tdata[21:14];
    assign in_has_current    = s_axis_tdata[22];
    assign in_current_index  = s_axis_tdata[32:23];
    assign in_cpu_number     = s_axis_tdata[35:33];

    state_t state_reg, state_next;

    logic               in_xfer;
    logic               yield_start;
    logic               out_free;
    logic               emit_load;

    logic [IDX_W-1:0]   clr_idx_reg;
    logic               has_cur_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [2:0]         cpu_reg;

    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_cnt_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_addr_reg;

    logic                     found_reg;
    logic [IDX_W-1:0]         pick_reg;
    logic [PRIORITY_BITS-1:0] pick_prio_reg;
    logic [2:0]               cur_status_reg;
    logic [PRIORITY_BITS-1:0] cur_prio_reg;
    logic                     any_reg;
    logic                     cpu_ok_reg;

    logic               m_valid_reg;
    decision_t          dec_reg, dec_next;
    logic [IDX_W-1:0]   chosen_reg, chosen_next;

    // RAM ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wentry;
    logic               ram_re;
    entry_t             rd_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    // Yield request decode
    logic               cur_in_range;
    logic [IDX_W-1:0]   cur_idx_in;
    logic [IDX_W-1:0]   start_idx;

    // Scan evaluation of the entry returned by the RAM
    logic               is_cur_entry;
    logic               is_candidate;
    logic               take_pick;
    logic               cpu_valid;
    logic               cpu_hit;

    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign yield_start = in_xfer && (s_axis_tuser == KIND_YIELD);
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign emit_load   = (state_reg == S_EMIT) && out_free;

    assign cur_in_range = 32'(in_current_index) < 32'(TASK_COUNT);
    assign cur_idx_in   = IDX_W'(in_current_index);
    assign start_idx    = (in_has_current && cur_in_range && cur_idx_in != LAST_IDX) ?
                          cur_idx_in + 1'b1 : '0;

    assign rd_entry     = entry_t'(ram_rdata);
    assign is_cur_entry = has_cur_reg && (rd_addr_reg == cur_reg);
    assign is_candidate = !rd_entry.is_idle && (rd_entry.status == ST_RUNNABLE) &&
                          !is_cur_entry;
    assign take_pick    = is_candidate && (!found_reg || rd_entry.prio < pick_prio_reg);
    assign cpu_valid    = (32'(cpu_reg) < 32'(TASK_COUNT)) && (32'(cpu_reg) < 32'(CPU_COUNT));
    assign cpu_hit      = cpu_valid && (rd_addr_reg == IDX_W'(cpu_reg));

    // Task table
    prrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (yield_start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Handshake and RAM control
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_idx_reg;
        ram_wentry    = '0;
        ram_re        = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                s_axis_tready      = 1'b1;
                ram_we             = in_xfer && (s_axis_tuser == KIND_WRITE) &&
                                     (32'(in_entry_index) < 32'(TASK_COUNT));
                ram_waddr          = IDX_W'(in_entry_index);
                ram_wentry.status  = in_entry_status;
                ram_wentry.is_idle = in_entry_is_idle;
                ram_wentry.prio    = PRIORITY_BITS'(in_entry_priority);
            end
            S_SCAN:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Final decision from the scan results
    always_comb
    begin
        dec_next    = DEC_NO_IDLE;
        chosen_next = '0;
        if (has_cur_reg && cur_status_reg == ST_RUNNING &&
            (!found_reg || cur_prio_reg < pick_prio_reg))
        begin
            dec_next    = DEC_CURRENT;
            chosen_next = cur_reg;
        end
        else if (found_reg)
        begin
            dec_next    = DEC_PICKED;
            chosen_next = pick_reg;
        end
        else if (!any_reg)
        begin
            dec_next = DEC_NONE;
        end
        else if (cpu_ok_reg)
        begin
            dec_next    = DEC_IDLE;
            chosen_next = IDX_W'(cpu_reg);
        end
    end

    // State, clearing pass and read sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            rd_idx_reg  <= '0;
            rd_cnt_reg  <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_SCAN);
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            // Advance the circular read address
            if (yield_start)
            begin
                rd_idx_reg <= start_idx;
                rd_cnt_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                rd_idx_reg <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end
    end

    // Tag of the entry that the RAM returns next cycle
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_idx_reg;
    end

    // Capture the request and fold each returned entry into the running results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_cur_reg    <= 1'b0;
            cur_reg        <= '0;
            cpu_reg        <= '0;
            found_reg      <= 1'b0;
            pick_reg       <= '0;
            pick_prio_reg  <= '0;
            cur_status_reg <= ST_FREE;
            cur_prio_reg   <= '0;
            any_reg        <= 1'b0;
            cpu_ok_reg     <= 1'b0;
        end
        else if (yield_start)
        begin
            has_cur_reg    <= in_has_current && cur_in_range;
            cur_reg        <= cur_idx_in;
            cpu_reg        <= in_cpu_number;
            found_reg      <= 1'b0;
            pick_reg       <= '0;
            pick_prio_reg  <= '0;
            cur_status_reg <= ST_FREE;
            cur_prio_reg   <= '0;
            any_reg        <= 1'b0;
            cpu_ok_reg     <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (take_pick)
            begin
                found_reg     <= 1'b1;
                pick_reg      <= rd_addr_reg;
                pick_prio_reg <= rd_entry.prio;
            end
            if (is_cur_entry)
            begin
                cur_status_reg <= rd_entry.status;
                cur_prio_reg   <= rd_entry.prio;
            end
            if (!rd_entry.is_idle &&
                (rd_entry.status == ST_RUNNABLE || rd_entry.status == ST_RUNNING))
            begin
                any_reg <= 1'b1;
            end
            if (cpu_hit)
            begin
                cpu_ok_reg <= (rd_entry.status == ST_RUNNABLE) ||
                              (rd_entry.status == ST_RUNNING);
            end
        end
    end

    // Output register: hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            dec_reg    <= dec_next;
            chosen_reg <= chosen_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, FIELD_IDX_W'(chosen_reg), dec_reg};

endmodule

@@ rtl/prrp_checker.sv @@
// Port-level checks of the task picker, bound to its top level.
`include "priority_round_robin_picker_macros.svh"

module prrp_checker
    import prrp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [2:0] dec;
    logic [9:0] chosen;
    logic       yield_xfer;

    assign dec        = m_axis_tdata[2:0];
    assign chosen     = m_axis_tdata[12:3];
    assign yield_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_YIELD);

    // A stalled result holds its value
    `PRRP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Decision codes stay within the defined set
    `PRRP_ASSERT_NOW(a_dec_legal, m_axis_tvalid, dec <= DEC_NO_IDLE)

    // No task index comes with "none runnable" or a missing idle task
    `PRRP_ASSERT_NOW(a_none_zero, m_axis_tvalid && (dec == DEC_NONE || dec == DEC_NO_IDLE), chosen == 10'd0)

    // An idle task sits at a CPU number
    `PRRP_ASSERT_NOW(a_idle_cpu, m_axis_tvalid && dec == DEC_IDLE, 32'(chosen) < 32'(CPU_COUNT))

    // A yield transfer closes the input while the table is scanned
    `PRRP_ASSERT_NEXT(a_yield_stall, yield_xfer, !s_axis_tready)

endmodule

bind priority_round_robin_picker prrp_checker u_prrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/picker_checker.sv @@
`timescale 1ns / 1ps
// Checker for the task picker: mirrors the task table, predicts each yield and compares.
module picker_checker
    import prrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    mismatch_count,
    output int                    decisions_owed
);

    // Input tdata layout, highest field first
    typedef struct packed {
        logic [3:0]             fill;
        logic [2:0]             cpu;
        logic [FIELD_IDX_W-1:0] cur_idx;
        logic                   has_cur;
        logic [7:0]             prio;
        logic                   is_idle;
        logic [2:0]             status;
        logic [FIELD_IDX_W-1:0] entry_idx;
    } request_t;

    typedef struct packed {
        decision_t              decision;
        logic [FIELD_IDX_W-1:0] index;
    } verdict_t;

    entry_t   task_table [TASK_COUNT];
    verdict_t due_decisions [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Work out what one yield must return from the mirrored table
    function automatic verdict_t pick_for_yield(input logic has_cur,
                                                input logic [FIELD_IDX_W-1:0] cur,
                                                input logic [2:0] cpu);
        verdict_t v;
        logic     cur_valid;
        logic     found;
        logic     any_live;
        int       pick;
        int       start;
        int       span;
        int       j;
        cur_valid = has_cur && (int'(cur) < TASK_COUNT);
        found     = 1'b0;
        any_live  = 1'b0;
        pick      = 0;
        if (cur_valid)
        begin
            start = int'(cur) + 1;
            span  = TASK_COUNT - 1;
        end
        else
        begin
            start = 0;
            span  = TASK_COUNT;
        end
        // Circular scan; strict compare keeps the first of equal priorities
        for (int k = 0; k < span; k++)
        begin
            j = (start + k) % TASK_COUNT;
            if (!task_table[j].is_idle && task_table[j].status == ST_RUNNABLE &&
                (!found || task_table[j].prio < task_table[pick].prio))
            begin
                pick  = j;
                found = 1'b1;
            end
        end
        for (int k = 0; k < TASK_COUNT; k++)
        begin
            if (!task_table[k].is_idle &&
                (task_table[k].status == ST_RUNNABLE || task_table[k].status == ST_RUNNING))
                any_live = 1'b1;
        end
        v.index = '0;
        if (cur_valid && task_table[cur].status == ST_RUNNING &&
            (!found || task_table[cur].prio < task_table[pick].prio))
        begin
            v.decision = DEC_CURRENT;
            v.index    = cur;
        end
        else if (found)
        begin
            v.decision = DEC_PICKED;
            v.index    = FIELD_IDX_W'(pick);
        end
        else if (!any_live)
            v.decision = DEC_NONE;
        else if (int'(cpu) < CPU_COUNT && int'(cpu) < TASK_COUNT &&
                 (task_table[cpu].status == ST_RUNNABLE ||
                  task_table[cpu].status == ST_RUNNING))
        begin
            v.decision = DEC_IDLE;
            v.index    = FIELD_IDX_W'(cpu);
        end
        else
            v.decision = DEC_NO_IDLE;
        return v;
    endfunction

    // Watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        request_t req;
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
                task_table[i] = '{status: ST_FREE, is_idle: 1'b0, prio: '0};
            due_decisions.delete();
            decisions_owed = 0;
            mismatch_count = 0;
        end
        else
        begin
            // Compare each result transfer with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_decisions.size() == 0)
                    report_mismatch($sformatf("result with no yield waiting, tdata %h",
                                              m_axis_tdata));
                else
                begin
                    want = due_decisions.pop_front();
                    decisions_owed = due_decisions.size();
                    if (m_axis_tdata[2:0] !== want.decision)
                        report_mismatch($sformatf("decision %0d, want %s",
                                                  m_axis_tdata[2:0], want.decision.name()));
                    if (m_axis_tdata[12:3] !== want.index)
                        report_mismatch($sformatf("chosen_index %0d, want %0d",
                                                  m_axis_tdata[12:3], want.index));
                end
            end
            // Apply writes to the mirror; predict yields
            if (s_axis_tvalid && s_axis_tready)
            begin
                req = request_t'(s_axis_tdata);
                if (s_axis_tuser == KIND_WRITE)
                begin
                    if (int'(req.entry_idx) < TASK_COUNT)
                        task_table[req.entry_idx] = '{status: req.status,
                                                      is_idle: req.is_idle,
                                                      prio: req.prio[PRIORITY_BITS-1:0]};
                end
                else if (s_axis_tuser == KIND_YIELD)
                begin
                    due_decisions.push_back(pick_for_yield(req.has_cur, req.cur_idx, req.cpu));
                    decisions_owed = due_decisions.size();
                end
            end
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the task picker bench: clock, reset, table writes and yields, and the verdict.
module testbench;
    import prrp_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 5000;
    localparam int SETTLE_CYCLES = TASK_COUNT + 64;
    localparam int RANDOM_ITEMS  = 140;
    localparam int LIVE_LIMIT    = 24;

    // Status codes with no name in the package
    localparam logic [2:0] ST_DYING   = 3'd1;
    localparam logic [2:0] ST_BLOCKED = 3'd4;
    localparam logic [2:0] ST_BOGUS   = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic hold_on         = 1'b0;
    logic hold_over       = 1'b0;
    int   items_sent      = 0;
    int   live_slots [$];
    int   mismatch_count;
    int   decisions_owed;

    priority_round_robin_picker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    picker_checker watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .decisions_owed (decisions_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: stall at random, and hold off completely during the long stretch
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = !(hold_on && !hold_over) &&
                            ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Count out the long hold-off once it is started
    initial
    begin
        wait (hold_on);
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_over = 1'b1;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[priority_round_robin_picker] ERROR");
        $finish;
    end

    // Offer one item, idling first at random; returns at the falling edge after the transfer
    task automatic transfer_item(input logic knd, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tuser  = knd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Table write; the yield fields carry random junk
    task automatic offer_write(input logic [FIELD_IDX_W-1:0] slot, input logic [2:0] status,
                               input logic idle_flag, input logic [7:0] prio);
        logic [IN_DATA_W-1:0] data;
        data = {4'b0, 3'($urandom), 10'($urandom), 1'($urandom), prio, idle_flag, status, slot};
        transfer_item(KIND_WRITE, data);
    endtask

    // Yield; the entry fields carry random junk
    task automatic offer_yield(input logic has_cur, input logic [FIELD_IDX_W-1:0] cur,
                               input logic [2:0] cpu);
        logic [IN_DATA_W-1:0] data;
        data = {4'b0, cpu, cur, has_cur, 8'($urandom), 1'($urandom), 3'($urandom),
                10'($urandom)};
        transfer_item(KIND_YIELD, data);
    endtask

    // Rounds of writes and yields, with the touched entries freed now and then
    task automatic run_traffic(input int target);
        int          slot;
        int          roll;
        logic [2:0]  status;
        logic        idle_flag;
        logic [7:0]  prio;
        while (items_sent < target)
        begin
            repeat ($urandom_range(1, 5))
            begin
                roll = $urandom_range(99);
                if (roll < 45 && live_slots.size() > 0)
                    slot = live_slots[$urandom_range(live_slots.size() - 1)];
                else if (roll < 70)
                    slot = $urandom_range(CPU_COUNT - 1);
                else
                    slot = $urandom_range(TASK_COUNT - 1);
                roll = $urandom_range(99);
                if (roll < 45)
                    status = ST_RUNNABLE;
                else if (roll < 65)
                    status = ST_RUNNING;
                else
                    status = 3'($urandom_range(7));
                if (slot < CPU_COUNT)
                    idle_flag = ($urandom_range(99) < 70);
                else
                    idle_flag = ($urandom_range(99) < 15);
                // Small priorities make ties common
                if ($urandom_range(1))
                    prio = 8'($urandom_range(3));
                else
                    prio = 8'($urandom_range(255));
                offer_write(FIELD_IDX_W'(slot), status, idle_flag, prio);
                live_slots.push_back(slot);
            end
            repeat ($urandom_range(1, 3))
            begin
                if (live_slots.size() > 0 && $urandom_range(99) < 60)
                    slot = live_slots[$urandom_range(live_slots.size() - 1)];
                else
                    slot = $urandom_range(TASK_COUNT - 1);
                offer_yield($urandom_range(99) < 75, FIELD_IDX_W'(slot),
                            3'($urandom_range(CPU_COUNT - 1)));
            end
            // Free everything touched so the empty-table cases come back
            if (live_slots.size() > LIVE_LIMIT || $urandom_range(4) == 0)
            begin
                foreach (live_slots[i])
                    offer_write(FIELD_IDX_W'(live_slots[i]), ST_FREE, 1'($urandom_range(1)),
                                8'($urandom_range(255)));
                live_slots.delete();
            end
        end
    endtask

    // Drop valid and wait until every yield has been answered
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (decisions_owed != 0) @(negedge clk);
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_WRITE;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling on either side
        offer_yield(1'b0, 10'd0, 3'd0);           // empty table: nothing runnable
        offer_yield(1'b1, 10'd1023, 3'd7);        // same, with a current task
        offer_write(10'd0, ST_RUNNABLE, 1'b1, 8'd0);     // idle task of CPU 0
        offer_write(10'd7, ST_RUNNING, 1'b1, 8'd255);    // idle task of CPU 7
        offer_write(10'd1023, ST_RUNNING, 1'b0, 8'd255);
        offer_yield(1'b0, 10'd0, 3'd0);           // only a running task: CPU 0 idles
        offer_yield(1'b0, 10'd0, 3'd3);           // CPU 3 has no idle task
        offer_yield(1'b1, 10'd1023, 3'd7);        // running current, nothing else: keep it
        offer_write(10'd512, ST_RUNNABLE, 1'b0, 8'd100);
        offer_write(10'd5, ST_RUNNABLE, 1'b0, 8'd100);
        offer_yield(1'b1, 10'd1023, 3'd1);        // tie across the wrap: first found wins
        offer_yield(1'b1, 10'd100, 3'd2);         // scan starts past a free current task
        offer_write(10'd1023, ST_RUNNING, 1'b0, 8'd0);
        offer_yield(1'b1, 10'd1023, 3'd0);        // current strictly better: keep it
        offer_write(10'd200, ST_RUNNABLE, 1'b0, 8'd0);
        offer_yield(1'b1, 10'd1023, 3'd0);        // tie with current: take the pick
        offer_write(10'd300, ST_RUNNABLE, 1'b1, 8'd0);   // idle entries are skipped
        offer_yield(1'b1, 10'd200, 3'd4);         // runnable current is left out of the scan
        offer_write(10'd5, ST_BOGUS, 1'b0, 8'd0);        // unused status code
        offer_write(10'd512, ST_DYING, 1'b0, 8'd0);
        offer_write(10'd200, ST_BLOCKED, 1'b0, 8'd0);
        offer_yield(1'b0, 10'd0, 3'd6);           // something runs but no idle task
        offer_yield(1'b1, 10'd1023, 3'd0);
        live_slots = '{0, 7, 1023, 512, 5, 200, 300};

        // No idling, with the long receiver hold-off at the start
        hold_on = 1'b1;
        run_traffic(items_sent + RANDOM_ITEMS);
        drain_results();

        // Sender idles most cycles
        sender_idle_pct = 80;
        run_traffic(items_sent + RANDOM_ITEMS);
        drain_results();

        // Receiver stalls most cycles
        sender_idle_pct = 0;
        recv_stall_pct  = 80;
        run_traffic(items_sent + RANDOM_ITEMS);
        drain_results();

        // Light idling on both sides
        sender_idle_pct = 20;
        recv_stall_pct  = 20;
        run_traffic(items_sent + RANDOM_ITEMS);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[priority_round_robin_picker] OK");
        else
            $display("[priority_round_robin_picker] ERROR");
        $finish;
    end

endmodule
